// File: hdl/clp_pkg.sv
package clp_pkg;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_char;
    } in_item_t;

    typedef struct packed {
        logic [2:0] cmd_kind;
        logic [6:0] first_number;
        logic [6:0] second_number;
        logic       straight;
    } out_item_t;

    typedef enum logic [2:0] {
        KIND_INVALID = 3'd0,
        KIND_TR      = 3'd1,
        KIND_RV      = 3'd2,
        KIND_SW      = 3'd3,
        KIND_Q       = 3'd4
    } kind_t;

    typedef enum logic [14:0] {
        PH_START     = 15'h0001,
        PH_GOT_T     = 15'h0002,
        PH_GOT_R     = 15'h0004,
        PH_GOT_S     = 15'h0008,
        PH_TRA_WAIT  = 15'h0010,
        PH_TRA_DIG   = 15'h0020,
        PH_TRB_WAIT  = 15'h0040,
        PH_TRB_DIG   = 15'h0080,
        PH_RV_WAIT   = 15'h0100,
        PH_RV_DIG    = 15'h0200,
        PH_SW_WAIT   = 15'h0400,
        PH_SW_DIG    = 15'h0800,
        PH_SW_LETTER = 15'h1000,
        PH_DONE      = 15'h2000,
        PH_FAIL      = 15'h4000
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [6:0] acc;
        logic [6:0] first;
        kind_t      kind;
        logic       straight;
    } parse_state_t;

    localparam parse_state_t PARSE_RESET = '{
        phase:    PH_START,
        acc:      7'd0,
        first:    7'd0,
        kind:     KIND_INVALID,
        straight: 1'b0
    };

    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_LO_T  = "t";
    localparam logic [7:0] CH_LO_R  = "r";
    localparam logic [7:0] CH_LO_S  = "s";
    localparam logic [7:0] CH_LO_Q  = "q";
    localparam logic [7:0] CH_LO_V  = "v";
    localparam logic [7:0] CH_LO_W  = "w";
    localparam logic [7:0] CH_UP_S  = "S";
    localparam logic [7:0] CH_UP_C  = "C";

    localparam logic [6:0] DEC_TEN = 7'd10;

    function automatic logic is_blank(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_dig_phase(phase_t p);
        return (p == PH_TRA_DIG) || (p == PH_TRB_DIG) ||
               (p == PH_RV_DIG) || (p == PH_SW_DIG);
    endfunction

    // A number is complete: store it and move on.
    function automatic parse_state_t take_number(parse_state_t s, logic [6:0] v);
        parse_state_t n;
        n = s;
        case (s.phase)
            PH_TRA_DIG:
            begin
                n.first = v;
                n.phase = PH_TRB_WAIT;
            end
            PH_TRB_DIG:
            begin
                n.acc   = v;
                n.kind  = KIND_TR;
                n.phase = PH_DONE;
            end
            PH_RV_DIG:
            begin
                n.first = v;
                n.acc   = 7'd0;
                n.kind  = KIND_RV;
                n.phase = PH_DONE;
            end
            PH_SW_DIG:
            begin
                n.first = v;
                n.phase = PH_SW_LETTER;
            end
            default:
            begin
                n = s;
            end
        endcase
        return n;
    endfunction

    // Every phase except the digit phases.
    function automatic parse_state_t handle_simple(parse_state_t s, logic [7:0] c);
        parse_state_t n;
        logic         blank;
        logic         dig;
        logic [7:0]   diff;
        n     = s;
        blank = is_blank(c);
        dig   = is_digit(c);
        diff  = c - CH_ZERO;
        case (s.phase)
            PH_START:
            begin
                if (!blank)
                begin
                    if (c == CH_LO_T)
                        n.phase = PH_GOT_T;
                    else if (c == CH_LO_R)
                        n.phase = PH_GOT_R;
                    else if (c == CH_LO_S)
                        n.phase = PH_GOT_S;
                    else if (c == CH_LO_Q)
                    begin
                        n.kind  = KIND_Q;
                        n.first = 7'd0;
                        n.acc   = 7'd0;
                        n.phase = PH_DONE;
                    end
                    else
                        n.phase = PH_FAIL;
                end
            end
            PH_GOT_T: n.phase = (c == CH_LO_R) ? PH_TRA_WAIT : PH_FAIL;
            PH_GOT_R: n.phase = (c == CH_LO_V) ? PH_RV_WAIT : PH_FAIL;
            PH_GOT_S: n.phase = (c == CH_LO_W) ? PH_SW_WAIT : PH_FAIL;
            PH_TRA_WAIT, PH_TRB_WAIT, PH_RV_WAIT, PH_SW_WAIT:
            begin
                if (!blank)
                begin
                    if (dig)
                    begin
                        n.acc = {3'd0, diff[3:0]};
                        case (s.phase)
                            PH_TRA_WAIT: n.phase = PH_TRA_DIG;
                            PH_TRB_WAIT: n.phase = PH_TRB_DIG;
                            PH_RV_WAIT:  n.phase = PH_RV_DIG;
                            default:     n.phase = PH_SW_DIG;
                        endcase
                    end
                    else
                        n.phase = PH_FAIL;
                end
            end
            PH_SW_LETTER:
            begin
                if (!blank)
                begin
                    if ((c == CH_UP_S) || (c == CH_UP_C))
                    begin
                        n.straight = (c == CH_UP_S);
                        n.acc      = 7'd0;
                        n.kind     = KIND_SW;
                        n.phase    = PH_DONE;
                    end
                    else
                        n.phase = PH_FAIL;
                end
            end
            default:
            begin
                n = s;
            end
        endcase
        return n;
    endfunction

    function automatic parse_state_t step_char(parse_state_t s, logic [7:0] c);
        parse_state_t n;
        logic [7:0]   diff;
        diff = c - CH_ZERO;
        if (is_dig_phase(s.phase))
        begin
            if (is_digit(c))
                n = take_number(s, 7'((s.acc * DEC_TEN) + {3'd0, diff[3:0]}));
            else
                // held digit stands alone, this byte opens the next field
                n = handle_simple(take_number(s, s.acc), c);
        end
        else
            n = handle_simple(s, c);
        return n;
    endfunction

endpackage

// File: hdl/command_line_parser_core.sv
// Channel | Signals                       | Item
// input   | in_valid, in_ready, in_data   | in_item_t  (char_in, last_char)
// output  | out_valid, out_ready, out_data| out_item_t (cmd_kind, numbers, straight)
//
// One item per cycle sustained while in_ready is high. An item waits in the
// input register; the parse update runs between it and the parser state /
// result register; out_valid rises as the final byte leaves the input register.
// Reset returns the parser to the start of a line and empties both registers.
// in_ready drops only while the input register holds a final byte and the
// result register is full and not being taken.
module command_line_parser_core
    import clp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic         in_valid_reg;
    logic         in_valid_next;
    in_item_t     in_data_reg;
    parse_state_t parse_reg;
    parse_state_t parse_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    out_item_t    out_data_reg;
    out_item_t    out_data_next;
    parse_state_t s_step;
    parse_state_t s_end;
    logic         advance;
    logic         emit;

    assign advance  = in_valid_reg &&
                      (!in_data_reg.last_char || !out_valid_reg || out_ready);
    assign emit     = advance && in_data_reg.last_char;
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        s_step = step_char(parse_reg, in_data_reg.char_in);
        s_end  = is_dig_phase(s_step.phase) ? take_number(s_step, s_step.acc) : s_step;

        if (s_end.phase == PH_DONE)
        begin
            out_data_next.cmd_kind      = s_end.kind;
            out_data_next.first_number  = s_end.first;
            out_data_next.second_number = (s_end.kind == KIND_TR) ? s_end.acc : 7'd0;
            out_data_next.straight      = (s_end.kind == KIND_SW) ? s_end.straight : 1'b0;
        end
        else
        begin
            out_data_next = '0;
        end

        if (advance)
            parse_next = in_data_reg.last_char ? PARSE_RESET : s_step;
        else
            parse_next = parse_reg;

        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            parse_reg     <= PARSE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            parse_reg     <= parse_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_data_reg <= in_data;
        if (emit)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: hdl/clp_checker.sv
module clp_checker
    import clp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // a waiting input item holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input item changed while waiting");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.cmd_kind == KIND_INVALID) |->
            (out_data.first_number == 7'd0) && (out_data.second_number == 7'd0) &&
            !out_data.straight)
        else $error("invalid line with nonzero fields");

    a_second_tr_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.cmd_kind != KIND_TR) |-> (out_data.second_number == 7'd0))
        else $error("second number outside tr");

    a_fields_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.cmd_kind <= KIND_Q) &&
            (out_data.first_number <= 7'd99) &&
            (out_data.second_number <= 7'd99) &&
            ((out_data.cmd_kind == KIND_SW) || !out_data.straight))
        else $error("bad kind, number out of range or stray S/C flag");

endmodule

bind command_line_parser_core clp_checker u_clp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
